/* rtl/assert_macros.svh */
// Assertion macros shared by the tracker RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge of clk.
`define ASSERT_ON_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge of clk.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* rtl/lmpt_pkg.sv */
// Types and constants of the lift motor position tracker.
// No dependencies; imported by every tracker module.
package lmpt_pkg;

	localparam int OPCODE_W   = 3;
	localparam int FLOOR_W    = 2;
	localparam int MASK_W     = 4;
	localparam int DUTY_W     = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int QDEPTH     = 2;

	// Opcodes of an input transaction
	localparam logic [OPCODE_W-1:0] OP_TICK  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_UP    = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_DOWN  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_STOP  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_CALL  = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_CLEAR = 3'd5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_DUTY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_POS   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UM_PULSE  = 2'd3;

	localparam logic [DUTY_W-1:0] RUN_DUTY_RST  = 10'd512;
	localparam logic [7:0]        MAX_PULSE_RST = 8'd220;
	localparam logic [7:0]        TOP_POS_RST   = 8'd180;
	localparam logic [11:0]       UM_PULSE_RST  = 12'd837;

	// Division by 1000: saturate above 255999, else (p >> 3) / 125 by reciprocal
	localparam logic [19:0] POS_SAT_LIMIT = 20'd256000;
	localparam logic [15:0] POS_RECIP     = 16'd33555;
	localparam int          POS_SHIFT     = 22;
	// Division by 100: saturate above 25599, else (p >> 2) / 25 by reciprocal
	localparam logic [19:0] SPD_SAT_LIMIT = 20'd25600;
	localparam logic [13:0] SPD_RECIP     = 14'd10486;
	localparam int          SPD_SHIFT     = 18;

	typedef enum logic [1:0] {
		MODE_STOP = 2'd0,
		MODE_UP   = 2'd1,
		MODE_DOWN = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		KIND_TICK  = 3'd0,
		KIND_UP    = 3'd1,
		KIND_DOWN  = 3'd2,
		KIND_STOP  = 3'd3,
		KIND_CALL  = 3'd4,
		KIND_CLEAR = 3'd5,
		KIND_NONE  = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         encoder;
		logic               sense_bottom;
		logic               sense_floor1;
		logic               sense_floor2;
		logic               sense_top;
		logic [FLOOR_W-1:0] call_floor;
		logic               call_is_down;
		logic [FLOOR_W-1:0] ref_floor;
	} cmd_t;

	typedef struct packed {
		mode_t              mode;
		logic               dir_down;
		logic [FLOOR_W-1:0] floor_no;
		logic               estop;
		logic               above;
		logic               below;
		logic [MASK_W-1:0]  up_mask;
		logic [MASK_W-1:0]  down_mask;
	} res_t;

endpackage

/* rtl/lmpt_if.sv */
// Stream interfaces of the tracker: input transactions and result transactions.
// Plain widths only; no package dependency.
interface lmpt_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [7:0] encoder_count;
	logic       bottom_sensor;
	logic       floor1_sensor;
	logic       floor2_sensor;
	logic       top_sensor;
	logic [1:0] call_floor;
	logic       call_is_down;
	logic [1:0] reference_floor;

	modport source (output valid, opcode, encoder_count, bottom_sensor, floor1_sensor,
		floor2_sensor, top_sensor, call_floor, call_is_down, reference_floor,
		input ready);
	modport sink (input valid, opcode, encoder_count, bottom_sensor, floor1_sensor,
		floor2_sensor, top_sensor, call_floor, call_is_down, reference_floor,
		output ready);
endinterface

interface lmpt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] position_mm;
	logic [7:0] speed_mm_s;
	logic [1:0] motor_mode;
	logic       direction_down;
	logic [9:0] drive_duty;
	logic [1:0] current_floor;
	logic       emergency_stop;
	logic       call_above;
	logic       call_below;
	logic [3:0] up_call_mask;
	logic [3:0] down_call_mask;

	modport source (output valid, position_mm, speed_mm_s, motor_mode, direction_down,
		drive_duty, current_floor, emergency_stop, call_above, call_below,
		up_call_mask, down_call_mask, input ready);
	modport sink (input valid, position_mm, speed_mm_s, motor_mode, direction_down,
		drive_duty, current_floor, emergency_stop, call_above, call_below,
		up_call_mask, down_call_mask, output ready);
endinterface

/* rtl/lift_motor_position_tracker.sv */
// Lift motor position tracker, top level.
// Depends on lmpt_pkg, lmpt_if, lmpt_front, lmpt_queue and lmpt_back.
//
// Takes one input transaction per clock unless out_ch.ready stalls the results, and
// returns one result per input in order. A result passes the queue, execute, scale
// and result registers in turn, and the block sustains one transaction per cycle:
// the pulse-total accumulator and call bits close their loop in the execute step,
// while the millimetre and mm/s scaling runs as a multiply stage and a reciprocal
// stage. The two-entry queue lets the input side keep running while a result waits.
// Configuration writes take effect on the next edge and belong in idle periods.
module lift_motor_position_tracker import lmpt_pkg::*; #(
	parameter int NUM_FLOORS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lmpt_in_if.sink               in_ch,
	lmpt_out_if.source            out_ch
);

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic pop;
	logic q_not_empty;
	cmd_t q_head;

	lmpt_front u_front (
		.in_ch    (in_ch),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	lmpt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	lmpt_back #(
		.NUM_FLOORS (NUM_FLOORS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.out_ch      (out_ch)
	);

endmodule

/* rtl/lmpt_queue.sv */
// Two-entry command queue between the decode front and the execute back.
// Depends on lmpt_pkg (cmd_t, QDEPTH) and assert_macros.svh.
`include "assert_macros.svh"

module lmpt_queue import lmpt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head
);

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	cmd_t             entry_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_NEVER(a_pop_empty, pop && count_q == '0, "queue popped while empty")
	`ASSERT_NEVER(a_push_full, push && full, "queue pushed while full")

endmodule

/* rtl/lmpt_front.sv */
// Front end: accepts input transactions and decodes them into queue commands.
// Depends on lmpt_pkg and the lmpt_in_if interface.
module lmpt_front import lmpt_pkg::*; (
	lmpt_in_if.sink in_ch,
	input  logic    q_full,
	output logic    push,
	output cmd_t    push_cmd
);

	kind_t kind;

	always_comb begin
		unique case (in_ch.opcode)
			OP_TICK:  kind = KIND_TICK;
			OP_UP:    kind = KIND_UP;
			OP_DOWN:  kind = KIND_DOWN;
			OP_STOP:  kind = KIND_STOP;
			OP_CALL:  kind = KIND_CALL;
			OP_CLEAR: kind = KIND_CLEAR;
			default:  kind = KIND_NONE;
		endcase
	end

	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && !q_full;

	always_comb begin
		push_cmd.kind         = kind;
		push_cmd.encoder      = in_ch.encoder_count;
		push_cmd.sense_bottom = in_ch.bottom_sensor;
		push_cmd.sense_floor1 = in_ch.floor1_sensor;
		push_cmd.sense_floor2 = in_ch.floor2_sensor;
		push_cmd.sense_top    = in_ch.top_sensor;
		push_cmd.call_floor   = in_ch.call_floor;
		push_cmd.call_is_down = in_ch.call_is_down;
		push_cmd.ref_floor    = in_ch.reference_floor;
	end

endmodule

/* rtl/lmpt_back.sv */
// Back end: executes queued commands, holds tracker state and configuration,
// scales position and speed over two stages and drives the result register.
// Depends on lmpt_pkg, lmpt_out_if and assert_macros.svh.
`include "assert_macros.svh"

module lmpt_back import lmpt_pkg::*; #(
	parameter int NUM_FLOORS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  q_not_empty,
	input  cmd_t                  q_head,
	output logic                  pop,
	lmpt_out_if.source            out_ch
);

	localparam int MASK_N = (NUM_FLOORS < MASK_W) ? NUM_FLOORS : MASK_W;

	// configuration
	logic [DUTY_W-1:0] run_duty_q;
	logic [7:0]        max_pulse_q;
	logic [7:0]        top_pos_q;
	logic [11:0]       um_pulse_q;

	// tracker state
	logic [7:0]            pulse_q;
	logic [7:0]            last_enc_q;
	mode_t                 mode_q;
	logic                  dir_q;
	logic [FLOOR_W-1:0]    floor_q;
	logic [NUM_FLOORS-1:0] up_q;
	logic [NUM_FLOORS-1:0] down_q;
	logic [7:0]            position_q;
	logic [7:0]            speed_q;

	// pipeline
	logic        valid_s1, valid_s2, valid_s3;
	res_t        res_s1, res_s2, res_s3;
	logic        tick_s1, tick_s2;
	logic [7:0]  force_s1, force_s2;
	logic [7:0]  pulse_s1, delta_s1;
	logic [19:0] prod_pos_s2, prod_spd_s2;

	logic                  en;
	logic [7:0]            delta;
	logic [8:0]            sum;
	logic [7:0]            n_pulse;
	logic [7:0]            n_last;
	mode_t                 n_mode;
	logic                  n_dir;
	logic [FLOOR_W-1:0]    n_floor;
	logic [NUM_FLOORS-1:0] n_up;
	logic [NUM_FLOORS-1:0] n_down;
	logic                  n_estop;
	logic [7:0]            n_force;
	logic                  n_above, n_below;
	logic                  hit;
	logic [30:0]           pos_recip;
	logic [26:0]           spd_recip;
	logic [7:0]            pos_scaled, spd_scaled;

	assign en  = !valid_s3 || out_ch.ready;
	assign pop = q_not_empty && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_duty_q  <= RUN_DUTY_RST;
			max_pulse_q <= MAX_PULSE_RST;
			top_pos_q   <= TOP_POS_RST;
			um_pulse_q  <= UM_PULSE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RUN_DUTY:  run_duty_q  <= cfg_data[DUTY_W-1:0];
				CFG_MAX_PULSE: max_pulse_q <= cfg_data[7:0];
				CFG_TOP_POS:   top_pos_q   <= cfg_data[7:0];
				CFG_UM_PULSE:  um_pulse_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Execute one command against the tracker state
	always_comb begin
		delta   = q_head.encoder - last_enc_q;
		sum     = {1'b0, pulse_q} + {1'b0, delta};
		n_pulse = pulse_q;
		n_last  = last_enc_q;
		n_mode  = mode_q;
		n_dir   = dir_q;
		n_floor = floor_q;
		n_up    = up_q;
		n_down  = down_q;
		n_estop = 1'b0;
		n_force = '0;
		hit     = 1'b0;
		unique case (q_head.kind)
			KIND_TICK: begin
				n_last = q_head.encoder;
				if (mode_q == MODE_UP) begin
					n_pulse = (sum > {1'b0, max_pulse_q}) ? max_pulse_q : sum[7:0];
				end else if (mode_q == MODE_DOWN) begin
					n_pulse = (delta > pulse_q) ? '0 : pulse_q - delta;
				end
				// highest detected sensor wins; none detected keeps the floor
				if (q_head.sense_top) begin
					n_floor = 2'd3;
				end else if (q_head.sense_floor2) begin
					n_floor = 2'd2;
				end else if (q_head.sense_floor1) begin
					n_floor = 2'd1;
				end else if (q_head.sense_bottom) begin
					n_floor = 2'd0;
				end
				if (q_head.sense_bottom && mode_q == MODE_DOWN) begin
					n_mode  = MODE_STOP;
					n_estop = 1'b1;
					n_force = '0;
				end
				if (q_head.sense_top && mode_q == MODE_UP) begin
					n_mode  = MODE_STOP;
					n_estop = 1'b1;
					n_force = top_pos_q;
				end
			end
			KIND_UP: begin
				n_dir  = 1'b0;
				n_mode = MODE_UP;
			end
			KIND_DOWN: begin
				n_dir  = 1'b1;
				n_mode = MODE_DOWN;
			end
			KIND_STOP: begin
				n_mode = MODE_STOP;
			end
			KIND_CALL: begin
				for (int f = 0; f < NUM_FLOORS; f++) begin
					if (32'(q_head.call_floor) == f) begin
						if (q_head.call_is_down) begin
							n_down[f] = 1'b1;
						end else begin
							n_up[f] = 1'b1;
						end
					end
				end
			end
			KIND_CLEAR: begin
				for (int f = 0; f < NUM_FLOORS; f++) begin
					hit = (32'(floor_q) == f);
					if (hit && (mode_q != MODE_DOWN || 32'(floor_q) == NUM_FLOORS - 1)) begin
						n_up[f] = 1'b0;
					end
					if (hit && (mode_q != MODE_UP || floor_q == '0)) begin
						n_down[f] = 1'b0;
					end
				end
			end
			default: ;
		endcase

		n_above = 1'b0;
		n_below = 1'b0;
		for (int f = 0; f < NUM_FLOORS; f++) begin
			if (n_up[f] || n_down[f]) begin
				if (f > 32'(q_head.ref_floor)) begin
					n_above = 1'b1;
				end
				if (f < 32'(q_head.ref_floor)) begin
					n_below = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q    <= '0;
			last_enc_q <= '0;
			mode_q     <= MODE_STOP;
			dir_q      <= 1'b0;
			floor_q    <= '0;
			up_q       <= '0;
			down_q     <= '0;
		end else if (pop) begin
			pulse_q    <= n_pulse;
			last_enc_q <= n_last;
			mode_q     <= n_mode;
			dir_q      <= n_dir;
			floor_q    <= n_floor;
			up_q       <= n_up;
			down_q     <= n_down;
		end
	end

	// Stage 1: command outcome
	always_ff @(posedge clk) begin
		if (en) begin
			res_s1.mode      <= n_mode;
			res_s1.dir_down  <= n_dir;
			res_s1.floor_no  <= n_floor;
			res_s1.estop     <= n_estop;
			res_s1.above     <= n_above;
			res_s1.below     <= n_below;
			res_s1.up_mask   <= MASK_W'(n_up[MASK_N-1:0]);
			res_s1.down_mask <= MASK_W'(n_down[MASK_N-1:0]);
			tick_s1          <= (q_head.kind == KIND_TICK);
			force_s1         <= n_force;
			pulse_s1         <= n_pulse;
			delta_s1         <= delta;
		end
	end

	// Stage 2: scale by travel per pulse
	always_ff @(posedge clk) begin
		if (en) begin
			res_s2      <= res_s1;
			tick_s2     <= tick_s1;
			force_s2    <= force_s1;
			prod_pos_s2 <= {12'd0, pulse_s1} * {8'd0, um_pulse_q};
			prod_spd_s2 <= {12'd0, delta_s1} * {8'd0, um_pulse_q};
		end
	end

	// Divide by constants through reciprocals, saturating at 255
	always_comb begin
		pos_recip  = {16'd0, prod_pos_s2[17:3]} * {15'd0, POS_RECIP};
		spd_recip  = {14'd0, prod_spd_s2[14:2]} * {13'd0, SPD_RECIP};
		pos_scaled = (prod_pos_s2 >= POS_SAT_LIMIT) ? 8'hFF : pos_recip[POS_SHIFT +: 8];
		spd_scaled = (prod_spd_s2 >= SPD_SAT_LIMIT) ? 8'hFF : spd_recip[SPD_SHIFT +: 8];
	end

	// Stage 3: result register; position and speed persist across non-tick items
	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= res_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			speed_q    <= '0;
		end else if (en && valid_s2 && tick_s2) begin
			position_q <= res_s2.estop ? force_s2 : pos_scaled;
			speed_q    <= spd_scaled;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign out_ch.valid          = valid_s3;
	assign out_ch.position_mm    = position_q;
	assign out_ch.speed_mm_s     = speed_q;
	assign out_ch.motor_mode     = res_s3.mode;
	assign out_ch.direction_down = res_s3.dir_down;
	assign out_ch.drive_duty     = (res_s3.mode != MODE_STOP) ? run_duty_q : '0;
	assign out_ch.current_floor  = res_s3.floor_no;
	assign out_ch.emergency_stop = res_s3.estop;
	assign out_ch.call_above     = res_s3.above;
	assign out_ch.call_below     = res_s3.below;
	assign out_ch.up_call_mask   = res_s3.up_mask;
	assign out_ch.down_call_mask = res_s3.down_mask;

	`ASSERT_ON_CLK(a_estop_halts, valid_s1 && res_s1.estop |-> res_s1.mode == MODE_STOP, "limit stop left motor running")
	`ASSERT_ON_CLK(a_estop_pos, en && valid_s2 && res_s2.estop |=> position_q == $past(force_s2), "limit stop position not forced")
	`ASSERT_ON_CLK(a_hold_pos, en && valid_s2 && !tick_s2 |=> $stable(position_q), "non-tick item moved position")

endmodule
